FILE: rtl/core/u8dec_pkg.sv
// Package for the UTF-8 byte stream decoder.
// Holds field widths and result status codes; no dependencies.
package u8dec_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CodeW   = 16;
    localparam int unsigned StatW   = 2;
    localparam int unsigned LenW    = 2;
    localparam int unsigned PayW    = 10;

    typedef logic [StatW-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_CONT = 2'd1;
    localparam t_status ST_INCOMPL  = 2'd2;
    localparam t_status ST_BAD_LEAD = 2'd3;

endpackage

FILE: rtl/core/utf8_byte_stream_decoder_unit.sv
// Top level of the UTF-8 byte stream decoder.
// Uses u8dec_pkg for widths and status codes.
//
// Input channel: i_valid / o_ready carry one raw byte (i_data_byte) per request.
// Output channel: o_valid / i_ready carry one decoded result per request:
// o_code_point, o_status, o_seq_length and o_last (set on the final result
// caused by a byte). Lead and middle bytes of a sequence give no result.
// A result is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while results are taken and no second
// result waits. A zero byte inside a sequence gives two results; the second
// waits in a one-entry pending slot and o_ready stays low until it moves out.
// The decoder state is updated in the cycle a byte is accepted, directly
// from the byte and the partial character held in registers.
// Reset (synchronous, active low) clears the partial character, the output
// valid flag and the pending slot.
// When the receiver stalls, the result register holds; o_ready stays low
// while the register is full and not taken, and while a second result waits.
module utf8_byte_stream_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [u8dec_pkg::ByteW-1:0] i_data_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u8dec_pkg::CodeW-1:0] o_code_point,
    output u8dec_pkg::t_status          o_status,
    output logic [u8dec_pkg::LenW-1:0]  o_seq_length,
    output logic                        o_last
);

    logic [1:0]                  r_remaining, n_remaining;
    logic [u8dec_pkg::PayW-1:0]  r_payload,   n_payload;
    logic [u8dec_pkg::LenW-1:0]  r_taken,     n_taken;
    logic                        r_cont_err,  n_cont_err;
    logic                        r_pend,      n_pend;
    logic                        r_out_valid, n_out_valid;
    logic [u8dec_pkg::CodeW-1:0] r_code,      n_code;
    u8dec_pkg::t_status          r_status,    n_status;
    logic [u8dec_pkg::LenW-1:0]  r_len,       n_len;
    logic                        r_last,      n_last;

    logic                        accept;
    logic                        out_free;
    logic                        res_valid;
    logic                        res_two;
    logic [u8dec_pkg::CodeW-1:0] res_code;
    u8dec_pkg::t_status          res_status;
    logic [u8dec_pkg::LenW-1:0]  res_len;
    logic                        res_last;
    logic [u8dec_pkg::CodeW-1:0] merged;
    logic                        bad_form;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_pend && out_free;
    assign accept   = i_valid && o_ready;

    assign merged   = {r_payload, i_data_byte[5:0]};
    assign bad_form = (i_data_byte[7:6] != 2'b10);

    always_comb begin
        n_remaining = r_remaining;
        n_payload   = r_payload;
        n_taken     = r_taken;
        n_cont_err  = r_cont_err;
        res_valid   = 1'b0;
        res_two     = 1'b0;
        res_code    = '0;
        res_status  = u8dec_pkg::ST_OK;
        res_len     = 2'd1;
        res_last    = 1'b1;
        if (r_remaining == 2'd0) begin
            if (!i_data_byte[7]) begin
                res_valid = 1'b1;
                res_code  = {{(u8dec_pkg::CodeW-u8dec_pkg::ByteW){1'b0}}, i_data_byte};
            end else if (i_data_byte[7:5] == 3'b110) begin
                n_remaining = 2'd1;
                n_payload   = {5'd0, i_data_byte[4:0]};
                n_taken     = 2'd1;
                n_cont_err  = 1'b0;
            end else if (i_data_byte[7:4] == 4'b1110) begin
                n_remaining = 2'd2;
                n_payload   = {6'd0, i_data_byte[3:0]};
                n_taken     = 2'd1;
                n_cont_err  = 1'b0;
            end else begin
                res_valid  = 1'b1;
                res_status = u8dec_pkg::ST_BAD_LEAD;
            end
        end else if (i_data_byte == '0) begin
            res_valid   = 1'b1;
            res_two     = 1'b1;
            res_status  = u8dec_pkg::ST_INCOMPL;
            res_len     = r_taken;
            res_last    = 1'b0;
            n_remaining = 2'd0;
            n_payload   = '0;
            n_taken     = 2'd0;
            n_cont_err  = 1'b0;
        end else if (r_remaining == 2'd1) begin
            res_valid   = 1'b1;
            res_code    = merged;
            res_status  = (r_cont_err || bad_form) ? u8dec_pkg::ST_BAD_CONT
                                                   : u8dec_pkg::ST_OK;
            res_len     = r_taken + 2'd1;
            n_remaining = 2'd0;
            n_payload   = '0;
            n_taken     = 2'd0;
            n_cont_err  = 1'b0;
        end else begin
            n_remaining = r_remaining - 2'd1;
            n_payload   = merged[u8dec_pkg::PayW-1:0];
            n_taken     = r_taken + 2'd1;
            n_cont_err  = r_cont_err || bad_form;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_code      = r_code;
        n_status    = r_status;
        n_len       = r_len;
        n_last      = r_last;
        n_pend      = r_pend;
        if (accept && res_valid) begin
            n_out_valid = 1'b1;
            n_code      = res_code;
            n_status    = res_status;
            n_len       = res_len;
            n_last      = res_last;
            n_pend      = res_two;
        end else if (r_pend && out_free) begin
            n_out_valid = 1'b1;
            n_code      = '0;
            n_status    = u8dec_pkg::ST_OK;
            n_len       = 2'd1;
            n_last      = 1'b1;
            n_pend      = 1'b0;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 2'd0;
            r_payload   <= '0;
            r_taken     <= '0;
            r_cont_err  <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_remaining <= n_remaining;
                r_payload   <= n_payload;
                r_taken     <= n_taken;
                r_cont_err  <= n_cont_err;
            end
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_status <= n_status;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_code;
    assign o_status     = r_status;
    assign o_seq_length = r_len;
    assign o_last       = r_last;

endmodule

FILE: rtl/core/u8dec_checker.sv
// Port-level checker for the UTF-8 byte stream decoder, bound to the top level.
// Uses u8dec_pkg status codes.
module u8dec_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [u8dec_pkg::CodeW-1:0] o_code_point,
    input u8dec_pkg::t_status          o_status,
    input logic [u8dec_pkg::LenW-1:0]  o_seq_length,
    input logic                        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_point) && $stable(o_status)
                                && $stable(o_seq_length) && $stable(o_last))
        else $error("result changed while stalled");

    a_incompl_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == u8dec_pkg::ST_INCOMPL |->
            o_code_point == '0 && !o_last && o_seq_length != 2'd0)
        else $error("malformed incomplete result");

    a_incompl_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_status == u8dec_pkg::ST_INCOMPL |=>
            o_valid && o_status == u8dec_pkg::ST_OK && o_code_point == '0
            && o_seq_length == 2'd1 && o_last)
        else $error("zero byte result missing after incomplete");

    a_bad_lead_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == u8dec_pkg::ST_BAD_LEAD |->
            o_code_point == '0 && o_seq_length == 2'd1 && o_last)
        else $error("malformed bad lead result");

    a_pending_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input accepted with second result pending");

endmodule

bind utf8_byte_stream_decoder_unit u8dec_checker u_u8dec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_code_point (o_code_point),
    .o_status     (o_status),
    .o_seq_length (o_seq_length),
    .o_last       (o_last)
);
